@@ design/crf_pkg.sv @@
// ----------------------------------------------------------------------------
// crf_pkg: shared types and constants of the circle raster fill engine
// Command codes, register indexes, the queue entry and a helper function.
// ----------------------------------------------------------------------------
package crf_pkg;

   localparam int DEFAULT_MAX_SIDE = 256;
   localparam int SIDE_W = 9;     // canvas size registers
   localparam int BG_W = 8;
   localparam int PIX_W = 8;
   localparam int COORD_W = 20;   // signed Q12.8 fields
   localparam int D_W = 22;       // signed distance from centre, Q.8
   localparam int SQ_W = 40;      // one squared distance term
   localparam int D2_W = SQ_W + 1;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SIDE_W-1:0] RESET_CANVAS_WIDTH = 9'd256;
   localparam logic [SIDE_W-1:0] RESET_CANVAS_HEIGHT = 9'd256;
   localparam logic [BG_W-1:0] RESET_BACKGROUND = 8'd32;
   localparam logic signed [D_W-1:0] ONE_PIXEL = 22'sd256;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CANVAS_WIDTH  = 2'd0,
      CSR_CANVAS_HEIGHT = 2'd1,
      CSR_BACKGROUND    = 2'd2
   } csr_index_type;

   // what the back end does with an item
   typedef enum logic [2:0] {
      K_CLEAR,
      K_DRAW,
      K_REJECT,
      K_READ,
      K_NONE
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DRAW,
      ST_DRAIN,
      ST_READ,
      ST_RESP
   } back_state_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [COORD_W-1:0]  center_x;
      logic signed [COORD_W-1:0]  center_y;
      logic [SQ_W-1:0]            r2;
      logic [SQ_W-1:0]            ri2;
      logic                       outline;
      logic [PIX_W-1:0]           paint;
      logic [PIX_W-1:0]           pixel_x;
      logic [PIX_W-1:0]           pixel_y;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // saturate a canvas size register to the framebuffer side
   function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v,
                                                 input int max_side);
      return (int'(v) > max_side) ? SIDE_W'(max_side) : v;
   endfunction

endpackage

@@ design/crf_front.sv @@
// ----------------------------------------------------------------------------
// crf_front: command intake
// Classifies each item and works out the squared radii before queueing it.
// ----------------------------------------------------------------------------
module crf_front
   import crf_pkg::*;
(
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic signed [COORD_W-1:0] req_radius,
   input  logic                      req_filled,
   input  logic [PIX_W-1:0]          req_paint,
   input  logic [PIX_W-1:0]          req_pixel_x,
   input  logic [PIX_W-1:0]          req_pixel_y,
   input  logic [SIDE_W-1:0]         eff_w,
   input  logic [SIDE_W-1:0]         eff_h,
   input  q_stat_type                q_stat,
   output logic                      push,
   output entry_type                 push_entry
);

   logic signed [2*COORD_W-1:0] r_sq;
   logic signed [COORD_W:0]     ri;
   logic signed [2*COORD_W+1:0] ri_sq;
   logic                        in_canvas;

   assign req_ready = !q_stat.full;
   assign push = req_valid && req_ready;

   assign r_sq = req_radius * req_radius;
   assign ri = (COORD_W+1)'(req_radius) - (COORD_W+1)'(ONE_PIXEL);
   assign ri_sq = ri * ri;
   assign in_canvas = ({1'b0, req_pixel_x} < eff_w) && ({1'b0, req_pixel_y} < eff_h);

   always_comb begin
      push_entry.center_x = req_center_x;
      push_entry.center_y = req_center_y;
      push_entry.r2 = r_sq[SQ_W-1:0];
      push_entry.ri2 = ri_sq[SQ_W-1:0];
      // below one pixel of radius there is no inner circle to cut out
      push_entry.outline = !req_filled && !ri[COORD_W];
      push_entry.paint = req_paint;
      push_entry.pixel_x = req_pixel_x;
      push_entry.pixel_y = req_pixel_y;
      unique case (req_command)
         CMD_CLEAR: push_entry.kind = K_CLEAR;
         CMD_DRAW:  push_entry.kind = (req_radius <= 0) ? K_REJECT : K_DRAW;
         CMD_READ:  push_entry.kind = in_canvas ? K_READ : K_NONE;
         default:   push_entry.kind = K_NONE;
      endcase
   end

endmodule

@@ design/crf_queue.sv @@
// ----------------------------------------------------------------------------
// crf_queue: command queue
// Short FIFO that parts the intake from the raster back end.
// ----------------------------------------------------------------------------
module crf_queue
   import crf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  entry_type  push_entry,
   input  logic       pop,
   output entry_type  head,
   output q_stat_type q_stat
);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + QPTR_W'(1);
   endfunction

   assign head = slot_ff[rd_ptr_ff];
   assign q_stat.full = (int'(count_ff) == QUEUE_DEPTH);
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ design/crf_back.sv @@
// ----------------------------------------------------------------------------
// crf_back: raster back end
// Owns the framebuffer; sweeps the canvas for clear and draw, reads pixels.
// ----------------------------------------------------------------------------
module crf_back
   import crf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE
)
(
   input  logic               clock,
   input  logic               reset,
   input  entry_type          head,
   input  q_stat_type         q_stat,
   output logic               pop,
   input  logic [SIDE_W-1:0]  eff_w,
   input  logic [SIDE_W-1:0]  eff_h,
   input  logic [BG_W-1:0]    background,
   output logic               res_valid,
   input  logic               res_ready,
   output logic [PIX_W-1:0]   res_pixel,
   output logic               res_status
);

   localparam int XW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMPW = ((XW > SIDE_W) ? XW : SIDE_W) + 1;

   back_state_type state_ff, state_in;

   logic [XW-1:0]             x_ff, x_in;
   logic [XW-1:0]             y_ff, y_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic [SQ_W-1:0]           r2_ff, r2_in;
   logic [SQ_W-1:0]           ri2_ff, ri2_in;
   logic                      outline_ff, outline_in;
   logic [PIX_W-1:0]          paint_ff, paint_in;
   logic                      status_ff, status_in;
   logic                      use_pix_ff, use_pix_in;

   logic                      s1_valid_ff, s1_valid_in;
   logic signed [D_W-1:0]     s1_dx_ff, s1_dx_in;
   logic signed [D_W-1:0]     s1_dy_ff, s1_dy_in;
   logic [AW-1:0]             s1_addr_ff;
   logic                      s2_valid_ff;
   logic [SQ_W-1:0]           s2_dx2_ff, s2_dy2_ff;
   logic [AW-1:0]             s2_addr_ff;

   logic [PIX_W-1:0]          fb_mem [DEPTH];
   logic [PIX_W-1:0]          rd_data_ff;

   logic                      last_x, last_y, issue, empty_canvas;
   logic [AW-1:0]             sweep_addr;
   logic signed [2*D_W-1:0]   dx_prod, dy_prod;
   logic [D2_W-1:0]           d2;
   logic                      hit;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [PIX_W-1:0]          wr_data;

   function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] px,
                                              input logic [XW-1:0] py);
      return AW'(py) * AW'(MAX_SIDE) + AW'(px);
   endfunction

   assign sweep_addr = pix_addr(x_ff, y_ff);
   assign last_x = (CMPW'(x_ff) + CMPW'(1)) == CMPW'(eff_w);
   assign last_y = (CMPW'(y_ff) + CMPW'(1)) == CMPW'(eff_h);
   assign empty_canvas = (eff_w == '0) || (eff_h == '0);
   assign issue = (state_ff == ST_DRAW);

   // draw pipeline: offsets, squares, compare and write
   assign s1_valid_in = issue;
   assign s1_dx_in = $signed(D_W'({x_ff, 8'h00})) - D_W'(cx_ff);
   assign s1_dy_in = $signed(D_W'({y_ff, 8'h00})) - D_W'(cy_ff);
   assign dx_prod = s1_dx_ff * s1_dx_ff;
   assign dy_prod = s1_dy_ff * s1_dy_ff;
   assign d2 = D2_W'(s2_dx2_ff) + D2_W'(s2_dy2_ff);
   assign hit = s2_valid_ff && (d2 <= D2_W'(r2_ff))
                && (!outline_ff || (d2 > D2_W'(ri2_ff)));

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = sweep_addr;
         wr_data = background;
      end else begin
         wr_en = hit;
         wr_addr = s2_addr_ff;
         wr_data = paint_ff;
      end
   end

   assign pop = (state_ff == ST_IDLE) && !q_stat.empty;
   assign res_valid = (state_ff == ST_RESP);
   assign res_pixel = use_pix_ff ? rd_data_ff : '0;
   assign res_status = status_ff;

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      y_in = y_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      r2_in = r2_ff;
      ri2_in = ri2_ff;
      outline_in = outline_ff;
      paint_in = paint_ff;
      status_in = status_ff;
      use_pix_in = use_pix_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               x_in = '0;
               y_in = '0;
               cx_in = head.center_x;
               cy_in = head.center_y;
               r2_in = head.r2;
               ri2_in = head.ri2;
               outline_in = head.outline;
               paint_in = head.paint;
               status_in = 1'b0;
               use_pix_in = 1'b0;
               case (head.kind)
                  K_CLEAR: state_in = empty_canvas ? ST_RESP : ST_CLEAR;
                  K_DRAW:  state_in = empty_canvas ? ST_RESP : ST_DRAW;
                  K_REJECT: begin
                     status_in = 1'b1;
                     state_in = ST_RESP;
                  end
                  K_READ: begin
                     x_in = XW'(head.pixel_x);
                     y_in = XW'(head.pixel_y);
                     use_pix_in = 1'b1;
                     state_in = ST_READ;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_CLEAR, ST_DRAW: begin
            if (last_x) begin
               x_in = '0;
               y_in = y_ff + XW'(1);
               if (last_y) begin
                  state_in = (state_ff == ST_CLEAR) ? ST_RESP : ST_DRAIN;
               end
            end else begin
               x_in = x_ff + XW'(1);
            end
         end
         ST_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff) begin
               state_in = ST_RESP;
            end
         end
         ST_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      r2_ff <= r2_in;
      ri2_ff <= ri2_in;
      outline_ff <= outline_in;
      paint_ff <= paint_in;
      status_ff <= status_in;
      use_pix_ff <= use_pix_in;
      s1_dx_ff <= s1_dx_in;
      s1_dy_ff <= s1_dy_in;
      s1_addr_ff <= sweep_addr;
      s2_dx2_ff <= dx_prod[SQ_W-1:0];
      s2_dy2_ff <= dy_prod[SQ_W-1:0];
      s2_addr_ff <= s1_addr_ff;
   end

   // framebuffer: one write port, one registered read port on the sweep address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         fb_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= fb_mem[sweep_addr];
   end

endmodule

@@ design/circle_raster_fill.sv @@
// ----------------------------------------------------------------------------
// circle_raster_fill: character framebuffer engine
// Clears the canvas, draws filled or outlined circles, reads single pixels.
// ----------------------------------------------------------------------------
//  port group  direction  handshake          contents
//  req_        in         valid / ready      command, centre, radius, mode, paint, pixel
//  rsp_        out        valid / ready      pixel_value, status
//  csr_        in         write enable only  canvas_width, canvas_height, background
//
//  Clear and draw sweep the canvas one pixel a cycle through the framebuffer
//  write port; draw also passes through the three-stage distance pipeline.
//  Reset is synchronous and clears the queue, the back end and the output
//  register; the framebuffer holds no reset value and needs a clear first.
//  A two-entry queue takes new items while the back end sweeps; a result
//  waits in the output register while the back end moves on.
// ----------------------------------------------------------------------------
module circle_raster_fill
   import crf_pkg::*;
#(
   parameter int MAX_SIDE = DEFAULT_MAX_SIDE
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic signed [COORD_W-1:0] req_radius,
   input  logic                      req_filled,
   input  logic [PIX_W-1:0]          req_paint,
   input  logic [PIX_W-1:0]          req_pixel_x,
   input  logic [PIX_W-1:0]          req_pixel_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PIX_W-1:0]          rsp_pixel_value,
   output logic                      rsp_status,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   logic [SIDE_W-1:0] canvas_width_ff, canvas_width_in;
   logic [SIDE_W-1:0] canvas_height_ff, canvas_height_in;
   logic [BG_W-1:0]   background_ff, background_in;
   logic [SIDE_W-1:0] eff_w, eff_h;

   logic              push, pop;
   entry_type         push_entry, head;
   q_stat_type        q_stat;

   logic              res_valid, res_ready, res_status;
   logic [PIX_W-1:0]  res_pixel;
   logic              rsp_valid_ff, rsp_status_ff;
   logic [PIX_W-1:0]  rsp_pixel_value_ff;

   always_comb begin
      canvas_width_in = canvas_width_ff;
      canvas_height_in = canvas_height_ff;
      background_in = background_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  canvas_width_in = csr_wdata;
            CSR_CANVAS_HEIGHT: canvas_height_in = csr_wdata;
            CSR_BACKGROUND:    background_in = csr_wdata[BG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_width_ff <= RESET_CANVAS_WIDTH;
         canvas_height_ff <= RESET_CANVAS_HEIGHT;
         background_ff <= RESET_BACKGROUND;
      end else begin
         canvas_width_ff <= canvas_width_in;
         canvas_height_ff <= canvas_height_in;
         background_ff <= background_in;
      end
   end

   assign eff_w = eff_side(canvas_width_ff, MAX_SIDE);
   assign eff_h = eff_side(canvas_height_ff, MAX_SIDE);

   crf_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .req_filled   (req_filled),
      .req_paint    (req_paint),
      .req_pixel_x  (req_pixel_x),
      .req_pixel_y  (req_pixel_y),
      .eff_w        (eff_w),
      .eff_h        (eff_h),
      .q_stat       (q_stat),
      .push         (push),
      .push_entry   (push_entry)
   );

   crf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   crf_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .eff_w      (eff_w),
      .eff_h      (eff_h),
      .background (background_ff),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_pixel  (res_pixel),
      .res_status (res_status)
   );

   // output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_pixel_value_ff <= res_pixel;
         rsp_status_ff <= res_status;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel_value = rsp_pixel_value_ff;
   assign rsp_status = rsp_status_ff;

   a_reject_no_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_pixel_value == '0)
      else $error("rejected draw returned a pixel value");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      res_valid && res_ready |=> rsp_valid)
      else $error("back end result lost before the output register");

   a_queue_count: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_stat.empty)
      else $error("queue reports full and empty at once");

   a_reset_clean: assert property (@(posedge clock)
      reset |=> !rsp_valid && q_stat.empty)
      else $error("result or queued item survived reset");

endmodule

@@ test/circle_raster_fill_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_raster_fill_checker: result predictor and comparator
// Tracks the canvas registers and a private copy of the framebuffer, works
// out the pixel value and status of every accepted command item and checks
// each result item against the oldest outstanding one.
// ----------------------------------------------------------------------------
module circle_raster_fill_checker
   import crf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [1:0]                req_command,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic signed [COORD_W-1:0] req_radius,
   input  logic                      req_filled,
   input  logic [PIX_W-1:0]          req_paint,
   input  logic [PIX_W-1:0]          req_pixel_x,
   input  logic [PIX_W-1:0]          req_pixel_y,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [PIX_W-1:0]          rsp_pixel_value,
   input  logic                      rsp_status,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   output int                        mismatch_count,
   output int                        results_owed
);

   localparam int SIDE = DEFAULT_MAX_SIDE;
   localparam longint PIXEL_STEP = 256;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             status;
   } pixel_result_type;

   logic [PIX_W-1:0]  canvas_mem [SIDE*SIDE];
   logic [SIDE_W-1:0] width_reg;
   logic [SIDE_W-1:0] height_reg;
   logic [BG_W-1:0]   bg_reg;
   pixel_result_type  expected_results [$];
   int                errors = 0;

   initial begin
      mismatch_count = 0;
      results_owed = 0;
   end

   function automatic int clip_side(input logic [SIDE_W-1:0] v);
      return (int'(v) > SIDE) ? SIDE : int'(v);
   endfunction

   // update the canvas copy and return what the block must answer
   function automatic pixel_result_type apply_command(
      input logic [1:0]                cmd,
      input logic signed [COORD_W-1:0] cx,
      input logic signed [COORD_W-1:0] cy,
      input logic signed [COORD_W-1:0] rad,
      input logic                      fill,
      input logic [PIX_W-1:0]          color,
      input logic [PIX_W-1:0]          px,
      input logic [PIX_W-1:0]          py
   );
      pixel_result_type res;
      int               w;
      int               h;
      int               x;
      int               y;
      longint           r2;
      longint           ri2;
      longint           dx;
      longint           dy;
      longint           d2;
      bit               has_inner;
      w = clip_side(width_reg);
      h = clip_side(height_reg);
      res = '0;
      case (cmd)
         CMD_CLEAR: begin
            for (y = 0; y < h; y++)
               for (x = 0; x < w; x++)
                  canvas_mem[y*SIDE + x] = bg_reg;
         end
         CMD_DRAW: begin
            if (rad <= 0) begin
               res.status = 1'b1;
            end else begin
               r2 = longint'(rad) * longint'(rad);
               has_inner = longint'(rad) >= PIXEL_STEP;
               ri2 = (longint'(rad) - PIXEL_STEP) * (longint'(rad) - PIXEL_STEP);
               for (y = 0; y < h; y++) begin
                  dy = longint'(y) * PIXEL_STEP - longint'(cy);
                  for (x = 0; x < w; x++) begin
                     dx = longint'(x) * PIXEL_STEP - longint'(cx);
                     d2 = dx*dx + dy*dy;
                     // a radius below one pixel has no inner circle to cut out
                     if (d2 <= r2 && (fill || !has_inner || d2 > ri2))
                        canvas_mem[y*SIDE + x] = color;
                  end
               end
            end
         end
         CMD_READ: begin
            if (px < w && py < h)
               res.pixel_value = canvas_mem[int'(py)*SIDE + int'(px)];
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         width_reg = RESET_CANVAS_WIDTH;
         height_reg = RESET_CANVAS_HEIGHT;
         bg_reg = RESET_BACKGROUND;
         expected_results.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_CANVAS_WIDTH:  width_reg = csr_wdata;
               CSR_CANVAS_HEIGHT: height_reg = csr_wdata;
               CSR_BACKGROUND:    bg_reg = csr_wdata[BG_W-1:0];
               default: ;
            endcase
         end
         // retire the oldest expectation before queuing a new one
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result item with none outstanding: pixel_value %0d status %0d",
                      rsp_pixel_value, rsp_status);
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_pixel_value !== want.pixel_value) begin
                  $error("pixel_value mismatch: expected %0d, actual %0d",
                         want.pixel_value, rsp_pixel_value);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(apply_command(req_command, req_center_x,
               req_center_y, req_radius, req_filled, req_paint, req_pixel_x,
               req_pixel_y));
      end
      mismatch_count <= errors;
      results_owed <= expected_results.size();
   end

endmodule

@@ test/circle_raster_fill_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_raster_fill_tb: stimulus and verdict for the circle raster engine
// Runs directed clears, circle draws and pixel reads at the extreme canvas
// settings, then random phases under fresh settings, with random gaps on
// the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module circle_raster_fill_tb;
   import crf_pkg::*;

   localparam logic [1:0]             CMD_SPARE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 8;
   localparam int SETTLE_CYCLES = 10;
   localparam int PIX = 256;   // one pixel in Q12.8

   typedef struct packed {
      logic [1:0]                command;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] radius;
      logic                      filled;
      logic [PIX_W-1:0]          paint;
      logic [PIX_W-1:0]          pixel_x;
      logic [PIX_W-1:0]          pixel_y;
   } cmd_item_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_command = CMD_CLEAR;
   logic signed [COORD_W-1:0] req_center_x = '0;
   logic signed [COORD_W-1:0] req_center_y = '0;
   logic signed [COORD_W-1:0] req_radius = '0;
   logic                      req_filled = 1'b0;
   logic [PIX_W-1:0]          req_paint = '0;
   logic [PIX_W-1:0]          req_pixel_x = '0;
   logic [PIX_W-1:0]          req_pixel_y = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PIX_W-1:0]          rsp_pixel_value;
   logic                      rsp_status;
   logic                      csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]    csr_index = CSR_CANVAS_WIDTH;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   int          mismatch_count;
   int          results_owed;
   int unsigned cycle_count = 0;
   bit          calm = 1'b0;
   int          cur_w = DEFAULT_MAX_SIDE;
   int          cur_h = DEFAULT_MAX_SIDE;
   int          sent_count [4] = '{default: 0};
   int          settings_used = 1;

   always #2 clock = ~clock;

   circle_raster_fill u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_radius      (req_radius),
      .req_filled      (req_filled),
      .req_paint       (req_paint),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_value (rsp_pixel_value),
      .rsp_status      (rsp_status),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   circle_raster_fill_checker u_checker (.*);

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: random stall bursts, none in the calm tail
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   // hold the item until accepted; leave valid high for a back-to-back item
   task automatic send_item(input cmd_item_type it);
      req_valid <= 1'b1;
      req_command <= it.command;
      req_center_x <= it.center_x;
      req_center_y <= it.center_y;
      req_radius <= it.radius;
      req_filled <= it.filled;
      req_paint <= it.paint;
      req_pixel_x <= it.pixel_x;
      req_pixel_y <= it.pixel_y;
      do @(posedge clock); while (!req_ready);
      sent_count[it.command]++;
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   function automatic cmd_item_type random_item(input logic [1:0] cmd);
      cmd_item_type it;
      it = cmd_item_type'({$urandom(), $urandom(), $urandom()});
      it.command = cmd;
      return it;
   endfunction

   task automatic do_clear();
      send_item(random_item(CMD_CLEAR));
   endtask

   task automatic do_spare();
      send_item(random_item(CMD_SPARE));
   endtask

   task automatic do_read(input int px, input int py);
      cmd_item_type it;
      it = random_item(CMD_READ);
      it.pixel_x = PIX_W'(px);
      it.pixel_y = PIX_W'(py);
      send_item(it);
   endtask

   task automatic do_draw(input int cx, input int cy, input int rad, input bit fill,
                          input int color);
      cmd_item_type it;
      it = random_item(CMD_DRAW);
      it.center_x = COORD_W'(cx);
      it.center_y = COORD_W'(cy);
      it.radius = COORD_W'(rad);
      it.filled = fill;
      it.paint = PIX_W'(color);
      send_item(it);
   endtask

   // circle near the canvas, sometimes thinner than one pixel
   task automatic random_draw();
      int span;
      int rad;
      span = (cur_w > cur_h) ? cur_w : cur_h;
      if ($urandom_range(0, 3) == 0) rad = $urandom_range(1, PIX - 1);
      else rad = $urandom_range(1, (span / 2 + 2) * PIX);
      do_draw(int'($urandom_range(0, (cur_w + 2) * PIX)) - PIX,
              int'($urandom_range(0, (cur_h + 2) * PIX)) - PIX,
              rad, 1'($urandom_range(0, 1)), $urandom_range(0, 255));
   endtask

   task automatic random_read();
      if (cur_w > 0 && cur_h > 0 && $urandom_range(0, 3) != 0)
         do_read($urandom_range(0, cur_w - 1), $urandom_range(0, cur_h - 1));
      else
         do_read($urandom_range(0, 255), $urandom_range(0, 255));
   endtask

   // stop sending and wait out every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(posedge clock);
   endtask

   task automatic set_canvas(input int w, input int h, input int bg);
      write_reg(CSR_CANVAS_WIDTH, w);
      write_reg(CSR_CANVAS_HEIGHT, h);
      write_reg(CSR_BACKGROUND, bg);
      csr_write_en <= 1'b0;
      @(posedge clock);
      cur_w = (w > DEFAULT_MAX_SIDE) ? DEFAULT_MAX_SIDE : w;
      cur_h = (h > DEFAULT_MAX_SIDE) ? DEFAULT_MAX_SIDE : h;
      settings_used++;
   endtask

   initial begin
      int sel;
      int w;
      int h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full 256x256 canvas at reset settings; nothing is read before the clear
      do_draw(PIX, PIX, 0, 1'b1, 'h11);
      do_draw(PIX, PIX, -524288, 1'b0, 'h22);
      do_spare();
      do_clear();
      do_read(0, 0);
      do_read(255, 255);
      do_draw(128 * PIX, 128 * PIX, 10 * PIX + 64, 1'b0, 'hA5);
      do_read(138, 128);
      do_read(128, 128);
      // huge disc with its edge landing exactly on the origin
      do_draw(524287, 0, 524287, 1'b1, 'hFF);
      do_read(255, 0);
      do_read(0, 255);
      do_read(0, 0);
      drain();

      // width saturates, single row; outline thinner than a pixel
      set_canvas(511, 1, 255);
      do_clear();
      do_draw(200 * PIX, 0, 128, 1'b0, 'h3C);
      do_read(200, 0);
      do_read(201, 0);
      do_read(0, 1);
      drain();

      set_canvas(1, 511, 0);
      do_clear();
      do_draw(0, 255 * PIX, 3 * PIX, 1'b1, 'h5A);
      do_read(0, 255);
      do_read(0, 251);
      drain();

      // empty canvas; the spare register index must be ignored
      set_canvas(0, 0, 'h77);
      write_reg(CSR_SPARE, 'h1FF);
      csr_write_en <= 1'b0;
      @(posedge clock);
      do_clear();
      do_draw(0, 0, 4 * PIX, 1'b1, 'h99);
      do_read(0, 0);
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) calm = 1'b1;
         case ($urandom_range(0, 5))
            0: begin w = $urandom_range(256, 511); h = $urandom_range(1, 2); end
            1: begin w = $urandom_range(1, 2); h = $urandom_range(256, 511); end
            2: begin w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 16); h = 0; end
            default: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
         endcase
         set_canvas(w, h, $urandom_range(0, 255));
         do_clear();
         repeat (PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) random_draw();
            else if (sel < 80) random_read();
            else if (sel < 88) do_clear();
            else if (sel < 94) send_item(random_item(CMD_DRAW));
            else do_spare();
         end
         drain();
      end

      $display("ran %0d clears, %0d draws, %0d reads and %0d spare commands",
               sent_count[CMD_CLEAR], sent_count[CMD_DRAW], sent_count[CMD_READ],
               sent_count[CMD_SPARE]);
      $display("across %0d canvas settings in %0d cycles", settings_used, cycle_count);
      if (mismatch_count == 0 && results_owed == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
design/crf_pkg.sv
design/crf_front.sv
design/crf_queue.sv
design/crf_back.sv
design/circle_raster_fill.sv
test/circle_raster_fill_checker.sv
test/circle_raster_fill_tb.sv
